// ===== rtl/drr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package drr_pkg;
  localparam int unsigned NumQueues  = 4;
  localparam int unsigned QueueDepth = 64;
  localparam int unsigned QIdxW      = 2;
  localparam int unsigned PtrW       = $clog2(QueueDepth);
  localparam int unsigned CntW       = $clog2(QueueDepth + 1);
  localparam int unsigned AddrW      = QIdxW + PtrW;
  localparam int unsigned LenW       = 16;
  localparam int unsigned DefW       = 20;
  localparam int unsigned LimW       = 7;
  localparam int unsigned RingCntW   = 3;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned FqDepth    = 2;

  localparam logic [CfgIdxW-1:0] RegQuantumBase = 3'd0;
  localparam logic [CfgIdxW-1:0] RegLimitBase   = 3'd4;

  typedef enum logic {
    ActEnqueue  = 1'b0,
    ActSchedule = 1'b1
  } action_e;

  typedef struct packed {
    action_e          action;
    logic [QIdxW-1:0] queue;
    logic [LenW-1:0]  length;
  } cmd_t;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StRead,
    StCheck,
    StDone
  } state_e;
endpackage
`default_nettype wire

// ===== rtl/drr_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module drr_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== rtl/drr_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module drr_front
  import drr_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  output logic                  busy_o,
  input  wire action_e          action_i,
  input  wire logic [QIdxW-1:0] queue_i,
  input  wire logic [LenW-1:0]  length_i,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output cmd_t                  cmd_o
);
  cmd_t        buf_q [FqDepth];
  logic        wr_q, rd_q;
  logic [1:0]  cnt_q;
  logic        push;

  assign busy_o  = (cnt_q == 2'(FqDepth));
  assign push    = start_i && !busy_o;
  assign valid_o = (cnt_q != 2'd0);
  assign cmd_o   = buf_q[rd_q];

  // hold incoming beats until the back end takes them
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_q] <= '{action: action_i, queue: queue_i, length: length_i};
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'(FqDepth) |-> !push) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("pop from empty queue");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(FqDepth)) else $error("count out of range");
`endif
endmodule
`default_nettype wire

// ===== rtl/drr_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module drr_back
  import drr_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [LenW-1:0]    cfg_data_i,
  input  wire logic               valid_i,
  input  wire cmd_t               cmd_i,
  output logic                    pop_o,
  output logic                    done_o,
  output logic                    enq_ok_o,
  output logic                    served_o,
  output logic [QIdxW-1:0]        served_queue_o,
  output logic [LenW-1:0]         served_length_o
);
  logic [LenW-1:0]     quantum_q [NumQueues];
  logic [LimW-1:0]     limit_q   [NumQueues];
  logic [PtrW-1:0]     head_q    [NumQueues];
  logic [CntW-1:0]     count_q   [NumQueues];
  logic [DefW-1:0]     deficit_q [NumQueues];
  logic [QIdxW-1:0]    ring_q    [NumQueues];
  logic [QIdxW-1:0]    rhead_q;
  logic [RingCntW-1:0] acount_q;
  logic [NumQueues-1:0] aflags_q;
  logic [RingCntW-1:0] passed_q;
  logic [RingCntW-1:0] iter_q;
  logic [QIdxW-1:0]    cur_q;
  cmd_t                cmd_q;
  state_e              state_q, state_d;

  logic                done_q, enq_ok_q, served_q;
  logic [QIdxW-1:0]    sq_q;
  logic [LenW-1:0]     sl_q;

  logic                we;
  logic [AddrW-1:0]    waddr, raddr;
  logic [LenW-1:0]     rdata;

  logic [CntW-1:0]     cap;
  logic [PtrW-1:0]     wpos;
  logic [QIdxW-1:0]    qi, cur;

  assign qi  = cmd_q.queue;
  assign cap = (limit_q[qi] < LimW'(QueueDepth)) ? CntW'(limit_q[qi]) : CntW'(QueueDepth);
  assign wpos = head_q[qi] + PtrW'(count_q[qi]);
  assign cur = ring_q[rhead_q];
  assign we = (state_q == StDone) && (cmd_q.action == ActEnqueue) &&
              (quantum_q[qi] != '0) && (count_q[qi] < cap);
  assign waddr = {qi, wpos};
  assign raddr = {cur_q, head_q[cur_q]};

  drr_ram #(.Width(LenW), .Depth(NumQueues * QueueDepth)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(cmd_q.length),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    case (state_q)
      StIdle: begin
        if (valid_i) begin
          pop_o   = 1'b1;
          state_d = (cmd_i.action == ActEnqueue) ? StDone : StScan;
        end
      end
      StScan: begin
        if (iter_q >= acount_q) state_d = StDone;
        else if (count_q[cur] != '0) state_d = StRead;
      end
      StRead:  state_d = StCheck;
      StCheck: state_d = (LenW+4)'(rdata) <= deficit_q[cur_q] ? StDone : StScan;
      StDone:  state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else         state_q <= state_d;
  end

  // configuration, ring walk and result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumQueues; i++) begin
        quantum_q[i] <= '0;
        limit_q[i]   <= LimW'(64);
        head_q[i]    <= '0;
        count_q[i]   <= '0;
        deficit_q[i] <= '0;
        ring_q[i]    <= '0;
      end
      rhead_q  <= '0;
      acount_q <= '0;
      aflags_q <= '0;
      passed_q <= '0;
      iter_q   <= '0;
      cur_q    <= '0;
      done_q   <= 1'b0;
      enq_ok_q <= 1'b0;
      served_q <= 1'b0;
      sq_q     <= '0;
      sl_q     <= '0;
    end else begin
      done_q <= 1'b0;
      if (cfg_we_i) begin
        if (cfg_idx_i < RegLimitBase)
          quantum_q[cfg_idx_i[QIdxW-1:0]] <= cfg_data_i;
        else
          limit_q[cfg_idx_i[QIdxW-1:0]] <= cfg_data_i[LimW-1:0];
      end
      case (state_q)
        StIdle: begin
          iter_q <= '0;
          if (valid_i) served_q <= 1'b0;
        end
        StScan: begin
          if (iter_q < acount_q) begin
            cur_q <= cur;
            if (passed_q == acount_q) begin
              // round complete: refill active deficits
              for (int i = 0; i < NumQueues; i++) begin
                if (aflags_q[i]) begin
                  deficit_q[i] <= ((DefW+1)'(deficit_q[i]) + (DefW+1)'(quantum_q[i]) >
                                   (DefW+1)'({DefW{1'b1}})) ? {DefW{1'b1}} :
                                  deficit_q[i] + DefW'(quantum_q[i]);
                end
              end
              passed_q <= '0;
            end
            if (count_q[cur] == '0) begin
              // drop empty queue from the ring
              rhead_q  <= rhead_q + 1'b1;
              acount_q <= acount_q - 1'b1;
              deficit_q[cur] <= '0;
              aflags_q[cur] <= 1'b0;
              iter_q <= iter_q + 1'b1;
            end
          end
        end
        StCheck: begin
          if ((LenW+4)'(rdata) <= deficit_q[cur_q]) begin
            deficit_q[cur_q] <= deficit_q[cur_q] - DefW'(rdata);
            head_q[cur_q]    <= head_q[cur_q] + 1'b1;
            count_q[cur_q]   <= count_q[cur_q] - 1'b1;
            served_q <= 1'b1;
            sq_q     <= cur_q;
            sl_q     <= rdata;
          end else begin
            // rotate to tail
            passed_q <= passed_q + 1'b1;
            ring_q[QIdxW'(rhead_q + QIdxW'(acount_q))] <= cur_q;
            rhead_q <= rhead_q + 1'b1;
            iter_q  <= iter_q + 1'b1;
          end
        end
        StDone: begin
          done_q   <= 1'b1;
          enq_ok_q <= we;
          if (cmd_q.action == ActEnqueue && quantum_q[qi] != '0) begin
            if (!aflags_q[qi]) begin
              if (acount_q < RingCntW'(NumQueues)) begin
                ring_q[QIdxW'(rhead_q + QIdxW'(acount_q))] <= qi;
                acount_q <= acount_q + 1'b1;
              end
              deficit_q[qi] <= DefW'(quantum_q[qi]);
              aflags_q[qi]  <= 1'b1;
            end
            if (we) count_q[qi] <= count_q[qi] + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && valid_i) cmd_q <= cmd_i;
  end

  assign done_o          = done_q;
  assign enq_ok_o        = enq_ok_q && (cmd_q.action == ActEnqueue);
  assign served_o        = served_q && (cmd_q.action == ActSchedule);
  assign served_queue_o  = served_o ? sq_q : '0;
  assign served_length_o = served_o ? sl_q : '0;

`ifndef SYNTHESIS
  a_ring_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acount_q <= RingCntW'(NumQueues)) else $error("ring overfull");
  a_flags_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StIdle |-> $countones(aflags_q) == int'(acount_q))
    else $error("ring count and flags disagree");
  a_serve_deficit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StCheck && (LenW+4)'(rdata) <= deficit_q[cur_q] |=> state_q == StDone)
    else $error("serve did not finish");
`endif
endmodule
`default_nettype wire

// ===== rtl/deficit_round_robin_scheduler_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Deficit round robin scheduler over four FIFOs of packet lengths. Items enter
// through start/busy into a two-entry command queue; a back end executes
// them one at a time and raises done_o for one cycle with the result, which
// must be taken then. An enqueue passes through the idle and done states; a
// schedule walks up to all 4 ring entries in the scan state, with a read and
// a check state for each non-empty queue, as the length memory read is registered.
module deficit_round_robin_scheduler_unit
  import drr_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [LenW-1:0]    cfg_data_i,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               action_i,
  input  wire logic [QIdxW-1:0]   queue_index_i,
  input  wire logic [LenW-1:0]    packet_length_i,
  output logic                    done_o,
  output logic                    enqueue_accepted_o,
  output logic                    served_o,
  output logic [QIdxW-1:0]        served_queue_o,
  output logic [LenW-1:0]         served_length_o
);
  logic pop, valid;
  cmd_t cmd;

  drr_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .action_i(action_e'(action_i)),
    .queue_i (queue_index_i),
    .length_i(packet_length_i),
    .pop_i   (pop),
    .valid_o (valid),
    .cmd_o   (cmd)
  );

  drr_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .valid_i        (valid),
    .cmd_i          (cmd),
    .pop_o          (pop),
    .done_o         (done_o),
    .enq_ok_o       (enqueue_accepted_o),
    .served_o       (served_o),
    .served_queue_o (served_queue_o),
    .served_length_o(served_length_o)
  );
endmodule
`default_nettype wire

// ===== tb/tb_deficit_round_robin_scheduler_unit.sv =====
`timescale 1ns / 1ps

module tb_deficit_round_robin_scheduler_unit;
  import drr_pkg::*;

  localparam int unsigned DefMax = 20'hFFFFF;

  // Register indexes as written on the configuration port
  localparam logic [CfgIdxW-1:0] RegQuantum0 = RegQuantumBase;
  localparam logic [CfgIdxW-1:0] RegLimit0   = RegLimitBase;

  // Golden scheduler state and expected result beats
  class drr_scoreboard;
    int unsigned quantum[NumQueues];
    int unsigned limit_cap[NumQueues];
    int unsigned len_fifo[NumQueues][$];
    int unsigned deficit[NumQueues];
    int unsigned ring[NumQueues];
    int unsigned ring_head;
    int unsigned active_cnt;
    bit [NumQueues-1:0] active;
    int unsigned passed_cnt;
    logic [QIdxW+LenW+1:0] pending[$];
    int unsigned mismatches;
    int unsigned served_cnt;
    int unsigned accepted_cnt;

    function new();
      for (int q = 0; q < NumQueues; q++) begin
        quantum[q] = 0;
        limit_cap[q] = 64;
        deficit[q] = 0;
        ring[q] = 0;
      end
      ring_head = 0;
      active_cnt = 0;
      active = '0;
      passed_cnt = 0;
      mismatches = 0;
      served_cnt = 0;
      accepted_cnt = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [LenW-1:0] val);
      if (idx < RegLimit0) quantum[idx] = val;
      else limit_cap[idx - RegLimit0] = val[LimW-1:0];
    endfunction

    function void refill();
      int unsigned d;
      for (int q = 0; q < NumQueues; q++) begin
        if (active[q]) begin
          d = deficit[q] + quantum[q];
          deficit[q] = (d > DefMax) ? DefMax : d;
        end
      end
      passed_cnt = 0;
    endfunction

    // Predict one accepted command and queue its result beat
    function void note_cmd(action_e act, logic [QIdxW-1:0] q, logic [LenW-1:0] len);
      bit acc;
      bit srv;
      int unsigned sq;
      int unsigned slen;
      int unsigned cap;
      int unsigned cur;
      int unsigned i;
      logic [QIdxW+LenW+1:0] beat;
      acc = 0;
      srv = 0;
      sq = 0;
      slen = 0;
      if (act == ActEnqueue) begin
        if (quantum[q] != 0) begin
          if (!active[q]) begin
            if (active_cnt < NumQueues) begin
              ring[(ring_head + active_cnt) % NumQueues] = q;
              active_cnt++;
            end
            deficit[q] = quantum[q];
            active[q] = 1'b1;
          end
          cap = (limit_cap[q] < QueueDepth) ? limit_cap[q] : QueueDepth;
          if (len_fifo[q].size() < cap) begin
            len_fifo[q] = {len_fifo[q], 32'(len)};
            acc = 1;
            accepted_cnt++;
          end
        end
      end else begin
        i = 0;
        while (i < active_cnt && !srv) begin
          if (passed_cnt == active_cnt) refill();
          cur = ring[ring_head];
          if (len_fifo[cur].size() != 0) begin
            if (len_fifo[cur][0] <= deficit[cur]) begin
              slen = len_fifo[cur].pop_front();
              deficit[cur] -= slen;
              sq = cur;
              srv = 1;
              served_cnt++;
            end else begin
              passed_cnt++;
              ring[(ring_head + active_cnt) % NumQueues] = cur;
              ring_head = (ring_head + 1) % NumQueues;
              i++;
            end
          end else begin
            ring_head = (ring_head + 1) % NumQueues;
            active_cnt--;
            deficit[cur] = 0;
            active[cur] = 1'b0;
            i++;
          end
        end
      end
      beat = {acc, srv, sq[QIdxW-1:0], slen[LenW-1:0]};
      pending = {pending, beat};
    endfunction

    // Compare a result beat against the oldest expectation
    function void check_beat(logic acc, logic srv, logic [QIdxW-1:0] sq,
                             logic [LenW-1:0] slen);
      logic [QIdxW+LenW+1:0] exp_beat;
      logic [QIdxW+LenW+1:0] got;
      got = {acc, srv, sq, slen};
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", got);
        return;
      end
      exp_beat = pending.pop_front();
      if (got !== exp_beat) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp acc=%0d srv=%0d q=%0d len=%0d, got acc=%0d srv=%0d q=%0d len=%0d",
                   exp_beat[QIdxW+LenW+1], exp_beat[QIdxW+LenW],
                   exp_beat[QIdxW+LenW-1:LenW], exp_beat[LenW-1:0], acc, srv, sq, slen);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [LenW-1:0] cfg_data_i;
  logic start;
  logic busy;
  logic action_i;
  logic [QIdxW-1:0] queue_index_i;
  logic [LenW-1:0] packet_length_i;
  logic done_o;
  logic enqueue_accepted_o;
  logic served_o;
  logic [QIdxW-1:0] served_queue_o;
  logic [LenW-1:0] served_length_o;

  drr_scoreboard sb;
  int unsigned cmd_cnt;

  deficit_round_robin_scheduler_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i),
    .start(start), .busy(busy),
    .action_i(action_i), .queue_index_i(queue_index_i), .packet_length_i(packet_length_i),
    .done_o(done_o), .enqueue_accepted_o(enqueue_accepted_o), .served_o(served_o),
    .served_queue_o(served_queue_o), .served_length_o(served_length_o)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Check every result beat at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && done_o)
      sb.check_beat(enqueue_accepted_o, served_o, served_queue_o, served_length_o);
  end

  task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [LenW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Drive one command beat; hold start until accepted
  task automatic send_cmd(action_e act, logic [QIdxW-1:0] q, logic [LenW-1:0] len,
                          bit keep);
    bit taken;
    start <= 1'b1;
    action_i <= act;
    queue_index_i <= q;
    packet_length_i <= len;
    taken = 0;
    while (!taken) begin
      @(posedge clk_i);
      if (!busy) begin
        taken = 1;
        sb.note_cmd(act, q, len);
        cmd_cnt++;
      end
      @(negedge clk_i);
    end
    if (!keep) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
  endtask

  // Random gap, mostly short, sometimes long
  task automatic gap();
    int unsigned n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    if (n != 0) start <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic random_cfg(int unsigned mode);
    for (int q = 0; q < NumQueues; q++) begin
      case (mode)
        0: write_cfg(CfgIdxW'(RegQuantum0 + q), LenW'($urandom_range(1, 3000)));
        1: write_cfg(CfgIdxW'(RegQuantum0 + q),
                     LenW'(($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 400)));
        2: write_cfg(CfgIdxW'(RegQuantum0 + q), 16'hFFFF);
        default: write_cfg(CfgIdxW'(RegQuantum0 + q), LenW'($urandom));
      endcase
      write_cfg(CfgIdxW'(RegLimit0 + q),
                LenW'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                  : $urandom_range(1, 8)));
    end
  endtask

  task automatic random_cmd();
    logic [LenW-1:0] len;
    case ($urandom_range(0, 3))
      0: len = LenW'($urandom);
      1: len = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: len = LenW'($urandom_range(1, 2000));
    endcase
    send_cmd($urandom_range(0, 9) < 5 ? ActEnqueue : ActSchedule,
             QIdxW'($urandom_range(0, 3)), len, 1'b1);
    gap();
  endtask

  initial begin
    sb = new();
    cmd_cnt = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    start = 1'b0;
    action_i = 1'b0;
    queue_index_i = '0;
    packet_length_i = '0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: absent queues reject, schedule on empty ring
    send_cmd(ActEnqueue, 2'd0, 16'd100, 1'b0);
    send_cmd(ActSchedule, 2'd0, 16'd0, 1'b0);
    drain();
    write_cfg(RegQuantum0, 16'd500);
    write_cfg(CfgIdxW'(RegQuantum0 + 1), 16'hFFFF);
    write_cfg(CfgIdxW'(RegQuantum0 + 2), 16'd1);
    write_cfg(CfgIdxW'(RegQuantum0 + 3), 16'd0);
    write_cfg(RegLimit0, 16'd2);
    write_cfg(CfgIdxW'(RegLimit0 + 1), 16'd127);
    write_cfg(CfgIdxW'(RegLimit0 + 2), 16'd0);
    write_cfg(CfgIdxW'(RegLimit0 + 3), 16'd64);
    // Drop at limit, zero length, max length, absent queue 3
    send_cmd(ActEnqueue, 2'd0, 16'd600, 1'b1);
    send_cmd(ActEnqueue, 2'd0, 16'd0, 1'b1);
    send_cmd(ActEnqueue, 2'd0, 16'd1, 1'b1);
    send_cmd(ActEnqueue, 2'd1, 16'hFFFF, 1'b1);
    send_cmd(ActEnqueue, 2'd2, 16'd5, 1'b1);
    send_cmd(ActEnqueue, 2'd3, 16'd5, 1'b1);
    repeat (10) send_cmd(ActSchedule, 2'd3, 16'hFFFF, 1'b1);
    send_cmd(ActEnqueue, 2'd1, 16'd7, 1'b0);
    drain();

    // Random phases with several settings, saturating quanta included
    for (int ph = 0; ph < 8; ph++) begin
      random_cfg(ph % 4);
      for (int k = 0; k < 200; k++) random_cmd();
      drain();
    end

    $display("ran %0d commands: %0d packets stored, %0d served", cmd_cnt,
             sb.accepted_cnt, sb.served_cnt);
    $display("covered zero/max quanta, limits 0..127, drops and ring refills");
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("deficit_round_robin_scheduler_unit regression: pass");
    end else begin
      $display("deficit_round_robin_scheduler_unit regression: fail");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("deficit_round_robin_scheduler_unit regression: fail");
    $finish;
  end
endmodule
